>>> design/ppf_pkg.sv
package ppf_pkg;

   typedef logic [2:0]  op_type;
   typedef logic [1:0]  state_type;
   typedef logic [31:0] frame_type;

   localparam op_type OP_FRAME = 3'd0;
   localparam op_type OP_PLAY  = 3'd1;
   localparam op_type OP_PAUSE = 3'd2;
   localparam op_type OP_STOP  = 3'd3;
   localparam op_type OP_SEEK  = 3'd4;

   localparam state_type ST_STOPPED  = 2'd0;
   localparam state_type ST_PLAYING  = 2'd1;
   localparam state_type ST_PAUSED   = 2'd2;
   localparam state_type ST_FINISHED = 2'd3;

   localparam logic [1:0] CSR_SAMPLE_IS_16BIT = 2'd0;
   localparam logic [1:0] CSR_STEREO          = 2'd1;
   localparam logic [1:0] CSR_VOLUME          = 2'd2;
   localparam logic [1:0] CSR_TOTAL_FRAMES    = 2'd3;

   localparam logic [8:0]  UNITY_GAIN = 9'd256;
   localparam frame_type   NOTICE_GAP = 32'd1000;
   localparam logic [16:0] U8_MIDPOINT = 17'd128;

   typedef struct packed {
      logic      consumed;
      logic      finished_now;
      logic      position_notice;
      state_type play_state;
   } status_type;

endpackage

>>> design/ppf_if.sv
interface ppf_req_if;
   logic                valid;
   logic                ready;
   ppf_pkg::op_type     op;
   logic [15:0]         raw_left;
   logic [15:0]         raw_right;
   ppf_pkg::frame_type  seek_sample;

   modport source (output valid, op, raw_left, raw_right, seek_sample, input ready);
   modport sink   (input valid, op, raw_left, raw_right, seek_sample, output ready);
endinterface

interface ppf_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  left_sample;
   logic signed [15:0]  right_sample;
   logic                consumed;
   logic                finished_now;
   logic                position_notice;
   ppf_pkg::state_type  play_state_out;

   modport source (output valid, left_sample, right_sample, consumed, finished_now,
                   position_notice, play_state_out, input ready);
   modport sink   (input valid, left_sample, right_sample, consumed, finished_now,
                   position_notice, play_state_out, output ready);
endinterface

>>> design/ppf_scaler.sv
module ppf_scaler (
   input  logic [15:0]        raw_left,
   input  logic [15:0]        raw_right,
   input  logic               sample_is_16bit,
   input  logic               stereo,
   input  logic [8:0]         volume,
   output logic signed [15:0] left_sample,
   output logic signed [15:0] right_sample
);
   import ppf_pkg::*;

   // One signed multiply per channel serves both sample formats. A 16-bit
   // product is divided by 256 rounding toward zero; an 8-bit one is used as is.
   function automatic logic signed [15:0] scale_one(input logic [15:0] raw,
                                                    input logic        is16,
                                                    input logic [8:0]  gain);
      logic signed [16:0] operand;
      logic signed [9:0]  gain_s;
      logic signed [26:0] product;
      logic signed [26:0] biased;
      if (is16) begin
         operand = signed'({raw[15], raw});
      end else begin
         operand = signed'({9'd0, raw[7:0]} - U8_MIDPOINT);
      end
      gain_s  = signed'({1'b0, gain});
      product = operand * gain_s;
      biased  = product + ((product < 0) ? 27'sd255 : 27'sd0);
      return is16 ? biased[23:8] : product[15:0];
   endfunction

   logic [8:0]         gain;
   logic signed [15:0] left_scaled;
   logic signed [15:0] right_scaled;

   assign gain         = (volume > UNITY_GAIN) ? UNITY_GAIN : volume;
   assign left_scaled  = scale_one(raw_left, sample_is_16bit, gain);
   assign right_scaled = scale_one(raw_right, sample_is_16bit, gain);

   assign left_sample  = left_scaled;
   assign right_sample = stereo ? right_scaled : left_scaled;

endmodule

>>> design/ppf_transport.sv
module ppf_transport (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ppf_pkg::op_type     op,
   input  ppf_pkg::frame_type  seek_sample,
   input  ppf_pkg::frame_type  total_frames,
   output ppf_pkg::status_type status
);
   import ppf_pkg::*;

   state_type play_state_ff, play_state_in;
   frame_type position_ff, position_in;
   frame_type last_notice_ff, last_notice_in;

   frame_type pos_next;
   frame_type notice_dist;

   // The position saturates instead of wrapping.
   assign pos_next    = (position_ff == '1) ? position_ff : position_ff + 32'd1;
   assign notice_dist = pos_next - last_notice_ff;

   always_comb begin
      play_state_in          = play_state_ff;
      position_in            = position_ff;
      last_notice_in         = last_notice_ff;
      status.consumed        = 1'b0;
      status.finished_now    = 1'b0;
      status.position_notice = 1'b0;
      case (op)
         OP_FRAME: begin
            if (play_state_ff == ST_PLAYING) begin
               status.consumed = 1'b1;
               position_in     = pos_next;
               if (pos_next >= total_frames) begin
                  play_state_in       = ST_FINISHED;
                  status.finished_now = 1'b1;
               end else if (notice_dist > NOTICE_GAP) begin
                  status.position_notice = 1'b1;
                  last_notice_in         = pos_next;
               end
            end
         end
         OP_PLAY: begin
            play_state_in = ST_PLAYING;
         end
         OP_PAUSE: begin
            if (play_state_ff == ST_PLAYING) begin
               play_state_in = ST_PAUSED;
            end else if (play_state_ff == ST_PAUSED) begin
               play_state_in = ST_PLAYING;
            end
         end
         OP_STOP: begin
            if (play_state_ff != ST_STOPPED) begin
               play_state_in = ST_STOPPED;
               position_in   = '0;
            end
         end
         OP_SEEK: begin
            position_in = (seek_sample < total_frames) ? seek_sample : total_frames;
         end
         default: begin
         end
      endcase
      status.play_state = play_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_state_ff  <= ST_STOPPED;
         position_ff    <= '0;
         last_notice_ff <= '0;
      end else if (advance) begin
         play_state_ff  <= play_state_in;
         position_ff    <= position_in;
         last_notice_ff <= last_notice_in;
      end
   end

endmodule

>>> design/pcm_playback_formatter.sv
// PCM playback formatter.
// The req channel carries one beat per event: a frame request with raw samples
// (8-bit unsigned in the low byte, or 16-bit signed), or a play, pause toggle,
// stop or seek command. Every req beat gives exactly one rsp beat holding the
// scaled stereo frame, the consumed, finished and position notice flags and the
// play state after the beat. Samples are zero and consumed is low unless a
// frame request arrives while playing.
// The csr port writes the format, channel count, Q8 volume and frame count;
// write it only while no beats are in flight.
// A req beat lands in the input register, and the scaler and transport logic
// feed the output register from it. Throughput is one beat per cycle while rsp
// does not stall, since the play state and position update as each beat leaves
// the input register.
// When the receiver stalls, the output register holds its beat and the input
// register takes one more; req.ready then drops until rsp drains.
// Reset clears both registers' valid flags, the play state to stopped, both
// positions to zero and the configuration to 16-bit stereo, unity gain, zero
// frames.
module pcm_playback_formatter (
   input  logic              clock,
   input  logic              reset,
   ppf_req_if.sink           req,
   ppf_rsp_if.source         rsp,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import ppf_pkg::*;

   logic       sample_is_16bit_ff;
   logic       stereo_ff;
   logic [8:0] volume_ff;
   frame_type  total_frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_is_16bit_ff <= 1'b1;
         stereo_ff          <= 1'b1;
         volume_ff          <= UNITY_GAIN;
         total_frames_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SAMPLE_IS_16BIT: sample_is_16bit_ff <= csr_wdata[0];
            CSR_STEREO:          stereo_ff          <= csr_wdata[0];
            CSR_VOLUME:          volume_ff          <= csr_wdata[8:0];
            CSR_TOTAL_FRAMES:    total_frames_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register.
   logic        in_valid_ff;
   op_type      op_ff;
   logic [15:0] raw_left_ff;
   logic [15:0] raw_right_ff;
   frame_type   seek_ff;

   logic rsp_valid_ff;
   logic advance;
   logic req_fire;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff        <= req.op;
         raw_left_ff  <= req.raw_left;
         raw_right_ff <= req.raw_right;
         seek_ff      <= req.seek_sample;
      end
   end

   logic signed [15:0] left_scaled;
   logic signed [15:0] right_scaled;
   status_type         status;

   ppf_scaler u_scaler (
      .raw_left        (raw_left_ff),
      .raw_right       (raw_right_ff),
      .sample_is_16bit (sample_is_16bit_ff),
      .stereo          (stereo_ff),
      .volume          (volume_ff),
      .left_sample     (left_scaled),
      .right_sample    (right_scaled)
   );

   ppf_transport u_transport (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .op           (op_ff),
      .seek_sample  (seek_ff),
      .total_frames (total_frames_ff),
      .status       (status)
   );

   // Output register.
   logic signed [15:0] left_ff;
   logic signed [15:0] right_ff;
   status_type         status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff   <= status.consumed ? left_scaled : 16'sd0;
         right_ff  <= status.consumed ? right_scaled : 16'sd0;
         status_ff <= status;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.left_sample     = left_ff;
   assign rsp.right_sample    = right_ff;
   assign rsp.consumed        = status_ff.consumed;
   assign rsp.finished_now    = status_ff.finished_now;
   assign rsp.position_notice = status_ff.position_notice;
   assign rsp.play_state_out  = status_ff.play_state;

endmodule

>>> design/ppf_checker.sv
module ppf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] left_sample,
   input logic signed [15:0] right_sample,
   input logic               consumed,
   input logic               finished_now,
   input logic               position_notice,
   input ppf_pkg::state_type play_state_out
);
   import ppf_pkg::*;

   // A stalled beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // A consumed frame leaves the player playing or finished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && consumed |->
         (play_state_out == ST_PLAYING || play_state_out == ST_FINISHED))
      else $error("consumed frame with wrong play state");

   // Reaching the end of data is only reported on a consumed frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && finished_now |-> consumed && play_state_out == ST_FINISHED)
      else $error("finished without consuming a frame");

   // Position notice never comes with the final frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && position_notice |-> consumed && !finished_now)
      else $error("bad position notice");

   // Frames not consumed are silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !consumed |-> left_sample == 16'sd0 && right_sample == 16'sd0)
      else $error("nonzero samples on silent beat");

endmodule

bind pcm_playback_formatter ppf_checker u_ppf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .left_sample     (rsp.left_sample),
   .right_sample    (rsp.right_sample),
   .consumed        (rsp.consumed),
   .finished_now    (rsp.finished_now),
   .position_notice (rsp.position_notice),
   .play_state_out  (rsp.play_state_out)
);

>>> test/pcm_playback_formatter_test.sv
`timescale 1ns / 1ps

module pcm_playback_formatter_test;
   import ppf_pkg::*;

   localparam int WATCHDOG_LIMIT = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASES         = 14;
   localparam int PHASE_ITEMS    = 125;

   // Op codes past seek are decoded as no-ops by the block.
   localparam op_type OP_SPARE_FIRST = 3'd5;
   localparam op_type OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic               consumed;
      logic               finished_now;
      logic               position_notice;
      state_type          play_state;
   } pcm_frame_type;

   typedef struct packed {
      logic          is_csr;
      logic [1:0]    csr_index;
      op_type        op;
      logic [15:0]   raw_left;
      logic [15:0]   raw_right;
      frame_type     arg;
      logic          typed;
      pcm_frame_type want;
   } plan_row_type;

   localparam pcm_frame_type UNCHECKED = '0;

   // Rows with typed set carry their own expected frame; csr rows put the data in arg.
   localparam plan_row_type DIRECTED_PLAN [0:34] = '{
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h7FFF, 16'h8000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_STOPPED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_STOPPED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_SPARE_LAST, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_STOPPED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PAUSE, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_STOPPED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_STOP, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_STOPPED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PLAY, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_PLAYING}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h7FFF, 16'h8000, 32'd0, 1'b1,
        '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 1'b0, ST_FINISHED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PAUSE, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_FINISHED}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PLAY, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_PLAYING}},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_STOP, 16'h0000, 16'h0000, 32'd0, 1'b1,
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, ST_STOPPED}},
      '{1'b1, CSR_TOTAL_FRAMES, OP_FRAME, 16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b0, UNCHECKED},
      '{1'b1, CSR_VOLUME, OP_FRAME, 16'h0000, 16'h0000, 32'd511, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_SEEK, 16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PLAY, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h8001, 16'h0001, 32'd0, 1'b0, UNCHECKED},
      '{1'b1, CSR_VOLUME, OP_FRAME, 16'h0000, 16'h0000, 32'd255, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PLAY, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_SEEK, 16'h0000, 16'h0000, 32'd1000, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h8001, 16'hFFFF, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_SEEK, 16'h0000, 16'h0000, 32'd3, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h0001, 16'h7FFF, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PAUSE, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h1234, 16'h5678, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_PAUSE, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b1, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b1, CSR_STEREO, OP_FRAME, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b1, CSR_VOLUME, OP_FRAME, 16'h0000, 16'h0000, 32'd128, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'hAB00, 16'h1234, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h12FF, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b1, CSR_VOLUME, OP_FRAME, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'hFFFF, 16'hFFFF, 32'd0, 1'b0, UNCHECKED},
      '{1'b1, CSR_STEREO, OP_FRAME, 16'h0000, 16'h0000, 32'd1, 1'b0, UNCHECKED},
      '{1'b1, CSR_VOLUME, OP_FRAME, 16'h0000, 16'h0000, 32'd256, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_FRAME, 16'h0080, 16'h0000, 32'd0, 1'b0, UNCHECKED},
      '{1'b0, CSR_SAMPLE_IS_16BIT, OP_STOP, 16'h0000, 16'h0000, 32'd0, 1'b0, UNCHECKED}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   ppf_req_if req_bus ();
   ppf_rsp_if rsp_bus ();

   pcm_playback_formatter uut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow of the player: configuration and transport state.
   logic       cfg_wide;
   logic       cfg_stereo;
   logic [8:0] cfg_volume;
   frame_type  cfg_total;
   state_type  player_state;
   frame_type  play_pos;
   frame_type  notice_pos;

   pcm_frame_type frames_due[$];
   int            mismatch_count = 0;
   int            beat_number = 0;
   int unsigned   rsp_stall = 0;
   int unsigned   quiet_cycles = 0;
   bit            no_idle = 1'b0;

   function automatic logic signed [15:0] scale_sample(logic [15:0] raw, logic [8:0] gain);
      int sample;
      if (cfg_wide) begin
         sample = $signed(raw);
         // Integer division truncates toward zero, as the block must.
         return 16'((sample * int'(gain)) / int'(UNITY_GAIN));
      end
      sample = int'(raw[7:0]) - int'(U8_MIDPOINT);
      return 16'(sample * int'(gain));
   endfunction

   function automatic pcm_frame_type advance_player(op_type op, logic [15:0] raw_l,
                                                    logic [15:0] raw_r, frame_type target);
      pcm_frame_type out;
      logic [8:0]    gain;
      frame_type     run_length;
      out = '0;
      gain = (cfg_volume > UNITY_GAIN) ? UNITY_GAIN : cfg_volume;
      case (op)
         OP_FRAME: begin
            if (player_state == ST_PLAYING) begin
               out.left_sample  = scale_sample(raw_l, gain);
               out.right_sample = cfg_stereo ? scale_sample(raw_r, gain) : out.left_sample;
               out.consumed     = 1'b1;
               if (play_pos != '1) play_pos = play_pos + 1;
               run_length = play_pos - notice_pos;
               if (play_pos >= cfg_total) begin
                  player_state     = ST_FINISHED;
                  out.finished_now = 1'b1;
               end else if (run_length > NOTICE_GAP) begin
                  out.position_notice = 1'b1;
                  notice_pos          = play_pos;
               end
            end
         end
         OP_PLAY: player_state = ST_PLAYING;
         OP_PAUSE: begin
            if (player_state == ST_PLAYING) player_state = ST_PAUSED;
            else if (player_state == ST_PAUSED) player_state = ST_PLAYING;
         end
         OP_STOP: begin
            if (player_state != ST_STOPPED) begin
               player_state = ST_STOPPED;
               play_pos     = '0;
            end
         end
         OP_SEEK: play_pos = (target < cfg_total) ? target : cfg_total;
         default: ;
      endcase
      out.play_state = player_state;
      return out;
   endfunction

   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         4: return 16'h0080;
         5: return 16'h007F;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH at beat %0d: %s", beat_number, msg);
   endtask

   // Called just after a falling edge; returns just after the falling edge that
   // follows the accepting rising edge.
   task automatic send_request(op_type op, logic [15:0] raw_l, logic [15:0] raw_r,
                               frame_type target, logic typed, pcm_frame_type want);
      int unsigned   gap;
      pcm_frame_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.op          = op;
      req_bus.raw_left    = raw_l;
      req_bus.raw_right   = raw_r;
      req_bus.seek_sample = target;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = advance_player(op, raw_l, raw_r, target);
      frames_due.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      req_bus.valid = 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = value;
      case (index)
         CSR_SAMPLE_IS_16BIT: cfg_wide = value[0];
         CSR_STEREO:          cfg_stereo = value[0];
         CSR_VOLUME:          cfg_volume = value[8:0];
         CSR_TOTAL_FRAMES:    cfg_total = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall != 0) begin
            rsp_bus.ready = 1'b0;
            rsp_stall--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_frame
      pcm_frame_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beat_number++;
         if (frames_due.size() == 0) begin
            flag_mismatch("output beat with no frame expected");
         end else begin
            want = frames_due.pop_front();
            if (rsp_bus.left_sample !== want.left_sample)
               flag_mismatch($sformatf("left_sample %0d, expected %0d",
                                       rsp_bus.left_sample, want.left_sample));
            if (rsp_bus.right_sample !== want.right_sample)
               flag_mismatch($sformatf("right_sample %0d, expected %0d",
                                       rsp_bus.right_sample, want.right_sample));
            if (rsp_bus.consumed !== want.consumed)
               flag_mismatch($sformatf("consumed %b, expected %b",
                                       rsp_bus.consumed, want.consumed));
            if (rsp_bus.finished_now !== want.finished_now)
               flag_mismatch($sformatf("finished_now %b, expected %b",
                                       rsp_bus.finished_now, want.finished_now));
            if (rsp_bus.position_notice !== want.position_notice)
               flag_mismatch($sformatf("position_notice %b, expected %b",
                                       rsp_bus.position_notice, want.position_notice));
            if (rsp_bus.play_state_out !== want.play_state)
               flag_mismatch($sformatf("play_state_out %0d, expected %0d",
                                       rsp_bus.play_state_out, want.play_state));
         end
         rsp_stall = no_idle ? 0 : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_en || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pcm_playback_formatter_test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int          pick;
      int          counted;
      op_type      op;
      logic [15:0] raw_l;
      logic [15:0] raw_r;
      frame_type   target;
      logic [31:0] reg_value;

      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = CSR_SAMPLE_IS_16BIT;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_FRAME;
      req_bus.raw_left    = '0;
      req_bus.raw_right   = '0;
      req_bus.seek_sample = '0;
      cfg_wide            = 1'b1;
      cfg_stereo          = 1'b1;
      cfg_volume          = UNITY_GAIN;
      cfg_total           = '0;
      player_state        = ST_STOPPED;
      play_pos            = '0;
      notice_pos          = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
         if (DIRECTED_PLAN[i].is_csr)
            write_register(DIRECTED_PLAN[i].csr_index, DIRECTED_PLAN[i].arg);
         else
            send_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].raw_left,
                         DIRECTED_PLAN[i].raw_right, DIRECTED_PLAN[i].arg,
                         DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         write_register(CSR_SAMPLE_IS_16BIT, 32'($urandom_range(0, 1)));
         write_register(CSR_STEREO, 32'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0: reg_value = '0;
            1: reg_value = 32'(UNITY_GAIN);
            2: reg_value = $urandom_range(257, 511);
            3: reg_value = $urandom_range(1, 255);
            default: reg_value = $urandom_range(0, 511);
         endcase
         write_register(CSR_VOLUME, reg_value);
         case ($urandom_range(0, 5))
            0: reg_value = '0;
            1: reg_value = $urandom_range(1, 40);
            2: reg_value = $urandom_range(40, 400);
            3: reg_value = $urandom_range(1000, 3000);
            4: reg_value = 32'hFFFFFFFF;
            default: reg_value = $urandom;
         endcase
         write_register(CSR_TOTAL_FRAMES, reg_value);
         no_idle = ($urandom_range(0, 3) == 0);

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            // Mostly frames while playing; keep the player from idling in a dead state.
            if (player_state != ST_PLAYING && pick < 25)
               op = (player_state == ST_FINISHED && pick < 12) ? OP_SEEK : OP_PLAY;
            else if (pick < 68) op = OP_FRAME;
            else if (pick < 75) op = OP_PLAY;
            else if (pick < 81) op = OP_PAUSE;
            else if (pick < 85) op = OP_STOP;
            else if (pick < 94) op = OP_SEEK;
            else op = op_type'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

            raw_l  = draw_sample();
            raw_r  = draw_sample();
            target = $urandom;
            if (op == OP_SEEK) begin
               case ($urandom_range(0, 5))
                  0: target = $urandom;
                  1: target = $urandom_range(cfg_total, 0);
                  // Land just short of the notice distance so a notice follows soon.
                  2: target = notice_pos + $urandom_range(985, 1000);
                  3: target = cfg_total;
                  4: target = cfg_total - $urandom_range(1, 3);
                  default: target = '0;
               endcase
            end
            send_request(op, raw_l, raw_r, target, 1'b0, UNCHECKED);
            counted++;
         end
      end

      req_bus.valid = 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("pcm_playback_formatter_test passed");
      end else begin
         $display("pcm_playback_formatter_test failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/ppf_pkg.sv
design/ppf_if.sv
design/ppf_scaler.sv
design/ppf_transport.sv
design/pcm_playback_formatter.sv
design/ppf_checker.sv
test/pcm_playback_formatter_test.sv
